// ===== rtl/core/homing_pd_position_motor_controller_defines.svh =====
// assertion macros for the homing pd position motor controller
`ifndef HOMING_PD_POSITION_MOTOR_CONTROLLER_DEFINES_SVH
`define HOMING_PD_POSITION_MOTOR_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define HPD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hpd assertion failed");
`define HPD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("hpd assertion failed");
`else
`define HPD_ASSERT(name, prop)
`define HPD_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ===== rtl/core/hpd_pkg.sv =====
// types, codes and constants shared by the homing pd position motor controller
package hpd_pkg;

  localparam int unsigned POS_BITS_DEF = 32;
  localparam int unsigned DUTY_MAX_DEF = 255;

  localparam int unsigned MODE_W     = 3;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned MSTATE_W   = 2;
  localparam int unsigned RAW_W      = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned MP_W       = 24;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // shared datapath width, holds kp*err + kd*der with both terms saturated
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned GAIN_FRAC = 8;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [FRAC_W-1:0]        FRAC_ONE    = 17'h10000;
  localparam logic [TICK_W-1:0]        TICK_MAX    = 16'hFFFF;
  localparam logic [ACC_W-1:0]         TRUNC_BIAS  = 64'd255;
  localparam logic signed [ACC_W-1:0]  SAT_HI      = 64'sd70368744177664;
  localparam logic signed [ACC_W-1:0]  SAT_LO      = -64'sd70368744177664;

  localparam logic [GAIN_W-1:0] KP_RST          = 16'd512;
  localparam logic [GAIN_W-1:0] KD_RST          = 16'd128;
  localparam logic [GAIN_W-1:0] DEAD_ZONE_RST   = 16'd5;
  localparam logic [MP_W-1:0]   MAX_PULSES_RST  = 24'd10000;
  localparam logic [DUTY_W-1:0] HOMING_DUTY_RST = 8'd80;
  localparam logic [TICK_W-1:0] STALL_TICKS_RST = 16'd500;
  localparam logic [DUTY_W-1:0] MIN_DUTY_RST    = 8'd40;

  // item modes
  localparam logic [MODE_W-1:0] MODE_EDGE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CTRL   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TARGET = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REHOME = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KD          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOMING_DUTY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_TICKS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY    = 3'd6;

  localparam logic [DIR_W-1:0] DIR_BRAKE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV   = 2'd2;

  localparam logic [MSTATE_W-1:0] MS_HOMING  = 2'd0;
  localparam logic [MSTATE_W-1:0] MS_MOVING  = 2'd1;
  localparam logic [MSTATE_W-1:0] MS_HOLDING = 2'd2;

  typedef enum logic [0:0] {
    OP_MUL,
    OP_DIV
  } hpd_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_TGT_MUL,
    S_PD_CHK,
    S_PD_KP,
    S_PD_KD,
    S_PD_OUT,
    S_PD_LIM,
    S_POS,
    S_DIV,
    S_EMIT
  } hpd_state_e;

  typedef struct packed {
    logic    start;
    hpd_op_e op;
    logic    keep_acc;
  } hpd_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hpd_stat_t;

  function automatic logic signed [ACC_W-1:0] sat46(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r;
  endfunction

endpackage

// ===== rtl/core/hpd_iter_unit.sv =====
// shared shift-add multiplier and restoring divider built on one adder
module hpd_iter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hpd_pkg::hpd_cmd_t                   cmd_i,
  input  logic signed [hpd_pkg::ACC_W-1:0]    opa_i,
  input  logic [hpd_pkg::MP_W-1:0]            opb_i,
  output hpd_pkg::hpd_stat_t                  stat_o,
  output logic signed [hpd_pkg::ACC_W-1:0]    acc_o,
  output logic [hpd_pkg::DIV_STEPS-1:0]       quo_o
);
  import hpd_pkg::*;

  logic                     busy_q, done_q;
  hpd_op_e                  op_q;
  logic signed [ACC_W-1:0]  acc_q, mcand_q;
  logic [MP_W-1:0]          mplier_q;
  logic [CNT_W-1:0]         cnt_q;

  logic signed [ACC_W-1:0]  add_a, add_b, sum;
  logic                     finish;

  always_comb begin
    add_a  = (op_q == OP_DIV) ? {acc_q[ACC_W-2:0], 1'b0} : acc_q;
    add_b  = ((op_q == OP_DIV) || mplier_q[0]) ? mcand_q : '0;
    sum    = add_a + add_b;
    finish = busy_q && ((op_q == OP_MUL) ? (mplier_q == '0) : (cnt_q == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= finish;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        op_q   <= cmd_i.op;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      if (cmd_i.op == OP_DIV) begin
        acc_q    <= opa_i;
        // divisor kept negated so the shared adder does the trial subtract
        mcand_q  <= -$signed({{(ACC_W-MP_W){1'b0}}, opb_i});
        mplier_q <= '0;
        cnt_q    <= CNT_W'(DIV_STEPS);
      end else begin
        acc_q    <= cmd_i.keep_acc ? acc_q : '0;
        mcand_q  <= opa_i;
        mplier_q <= opb_i;
        cnt_q    <= '0;
      end
    end else if (busy_q && !finish) begin
      if (op_q == OP_MUL) begin
        acc_q    <= sum;
        mcand_q  <= {mcand_q[ACC_W-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[MP_W-1:1]};
      end else begin
        // negative trial means the shifted remainder stays
        acc_q    <= sum[ACC_W-1] ? add_a : sum;
        mplier_q <= {mplier_q[MP_W-2:0], ~sum[ACC_W-1]};
        cnt_q    <= cnt_q - 1'b1;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign acc_o       = acc_q;
  assign quo_o       = mplier_q[DIV_STEPS-1:0];

endmodule

// ===== rtl/core/homing_pd_position_motor_controller.sv =====
// top level: homing pd position controller with encoder count and stall homing
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   mode, b_level, target_fraction
//   out      output     out_valid_o / out_stall_i bridge_dir, duty, motor_state,
//                                                 raw_position, position_fraction
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one item at a time; any item may run a position divide on the 64-bit adder of the
// shared multiply/divide unit, a set target item also a multiply, and a control
// update also one multiply each for the kp and kd terms
// reset starts the homing sequence at once, no clearing pass
// a finished result waits in the output register; the next item is accepted
// meanwhile and only its hand-off waits for out_stall_i to drop
`include "homing_pd_position_motor_controller_defines.svh"

module homing_pd_position_motor_controller #(
  parameter int unsigned POS_BITS = hpd_pkg::POS_BITS_DEF,
  parameter int unsigned DUTY_MAX = hpd_pkg::DUTY_MAX_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [hpd_pkg::MODE_W-1:0]         mode_i,
  input  logic                               b_level_i,
  input  logic [hpd_pkg::FRAC_W-1:0]         target_fraction_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [hpd_pkg::DIR_W-1:0]          bridge_dir_o,
  output logic [hpd_pkg::DUTY_W-1:0]         duty_o,
  output logic [hpd_pkg::MSTATE_W-1:0]       motor_state_o,
  output logic signed [hpd_pkg::RAW_W-1:0]   raw_position_o,
  output logic [hpd_pkg::FRAC_W-1:0]         position_fraction_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [hpd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import hpd_pkg::*;

  localparam int unsigned MAG_W = ($clog2(DUTY_MAX + 1) > DUTY_W) ?
                                  $clog2(DUTY_MAX + 1) : DUTY_W;
  localparam int unsigned DRV_W = MAG_W + 1;
  localparam int unsigned ERR_W = POS_BITS + 1;
  localparam int unsigned DER_W = POS_BITS + 2;
  localparam int unsigned TR_W  = ACC_W - GAIN_FRAC;

  localparam logic [MAG_W-1:0]        DMAX_MAG = MAG_W'(DUTY_MAX);
  localparam logic signed [DRV_W-1:0] DMAX_DRV = $signed({1'b0, DMAX_MAG});
  localparam logic signed [TR_W-1:0]  DMAX_TR  = $signed(TR_W'(DUTY_MAX));
  localparam logic signed [DRV_W-1:0] DRV_RST  =
    -$signed({{(DRV_W-DUTY_W){1'b0}}, HOMING_DUTY_RST});

  // configuration
  logic [GAIN_W-1:0] kp_q, kd_q, dz_q;
  logic [MP_W-1:0]   mp_q;
  logic [DUTY_W-1:0] hduty_q, mind_q;
  logic [TICK_W-1:0] stall_q;

  // sequencer and controller state
  hpd_state_e               state_q, state_d;
  logic [MODE_W-1:0]        mode_q;
  logic                     b_q;
  logic [FRAC_W-1:0]        frac_q;
  logic signed [POS_BITS-1:0] position_q, position_d, target_q, target_d;
  logic signed [ERR_W-1:0]  last_err_q, last_err_d, err_q, err_d;
  logic signed [DER_W-1:0]  der_q, der_d;
  logic                     homed_q, homed_d, moving_q, moving_d;
  logic signed [DRV_W-1:0]  drive_q, drive_d;
  logic [TICK_W-1:0]        idle_q, idle_d;
  logic signed [TR_W-1:0]   trunc_q, trunc_d;
  logic [FRAC_W-1:0]        pf_q, pf_d;

  // output register
  logic                     out_valid_q;
  logic [DIR_W-1:0]         dir_q;
  logic [DUTY_W-1:0]        duty_q;
  logic [MSTATE_W-1:0]      mstate_q;
  logic signed [RAW_W-1:0]  raw_q;
  logic [FRAC_W-1:0]        pfo_q;

  // shared unit
  hpd_cmd_t                 unit_cmd;
  hpd_stat_t                unit_stat;
  logic signed [ACC_W-1:0]  unit_opa, unit_acc;
  logic [MP_W-1:0]          unit_opb;
  logic [DIV_STEPS-1:0]     unit_quo;

  logic                     in_accept, emit;
  logic signed [ACC_W-1:0]  pos_ext, mp_ext, err_sat, der_sat, acc_bias;
  logic [ERR_W-1:0]         err_mag, dz_ext;
  logic                     in_dead_zone, pos_nonpos, pos_full;
  logic [TICK_W-1:0]        idle_inc;
  logic [FRAC_W-1:0]        frac_clamp;
  logic signed [DRV_W-1:0]  clamp, md_s, drv_mag;
  logic [MAG_W-1:0]         mind_ext, md_mag;

  hpd_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (unit_cmd),
    .opa_i  (unit_opa),
    .opb_i  (unit_opb),
    .stat_o (unit_stat),
    .acc_o  (unit_acc),
    .quo_o  (unit_quo)
  );

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= KP_RST;
      kd_q    <= KD_RST;
      dz_q    <= DEAD_ZONE_RST;
      mp_q    <= MAX_PULSES_RST;
      hduty_q <= HOMING_DUTY_RST;
      stall_q <= STALL_TICKS_RST;
      mind_q  <= MIN_DUTY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_KP:          kp_q    <= cfg_data_i[GAIN_W-1:0];
        REG_KD:          kd_q    <= cfg_data_i[GAIN_W-1:0];
        REG_DEAD_ZONE:   dz_q    <= cfg_data_i[GAIN_W-1:0];
        REG_MAX_PULSES:  mp_q    <= cfg_data_i[MP_W-1:0];
        REG_HOMING_DUTY: hduty_q <= cfg_data_i[DUTY_W-1:0];
        REG_STALL_TICKS: stall_q <= cfg_data_i[TICK_W-1:0];
        REG_MIN_DUTY:    mind_q  <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // shared helper values
  always_comb begin
    pos_ext    = {{(ACC_W-POS_BITS){position_q[POS_BITS-1]}}, position_q};
    mp_ext     = $signed({{(ACC_W-MP_W){1'b0}}, mp_q});
    pos_nonpos = (pos_ext <= 0);
    pos_full   = (pos_ext >= mp_ext);
    err_mag    = err_q[ERR_W-1] ? (~err_q + 1'b1) : err_q;
    dz_ext     = {{(ERR_W-GAIN_W){1'b0}}, dz_q};
    in_dead_zone = (err_mag <= dz_ext);
    err_sat    = sat46({{(ACC_W-ERR_W){err_q[ERR_W-1]}}, err_q});
    der_sat    = sat46({{(ACC_W-DER_W){der_q[DER_W-1]}}, der_q});
    idle_inc   = (idle_q != TICK_MAX) ? idle_q + 1'b1 : idle_q;
    frac_clamp = frac_q[FRAC_W-1] ? FRAC_ONE : frac_q;
    // truncation toward zero of the q56.8 sum
    acc_bias   = unit_acc + (unit_acc[ACC_W-1] ? TRUNC_BIAS : '0);
    mind_ext   = {{(MAG_W-DUTY_W){1'b0}}, mind_q};
    md_mag     = (mind_ext > DMAX_MAG) ? DMAX_MAG : mind_ext;
    md_s       = $signed({1'b0, md_mag});
    if (trunc_q > DMAX_TR) begin
      clamp = DMAX_DRV;
    end else if (trunc_q < -DMAX_TR) begin
      clamp = -DMAX_DRV;
    end else begin
      clamp = trunc_q[DRV_W-1:0];
    end
    drv_mag    = drive_q[DRV_W-1] ? -drive_q : drive_q;
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign emit      = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_accept) state_d = S_EXEC;
      S_EXEC: begin
        unique case (mode_q)
          MODE_CTRL:   state_d = homed_q ? S_PD_CHK : S_POS;
          MODE_TARGET: state_d = S_TGT_MUL;
          default:     state_d = S_POS;
        endcase
      end
      S_TGT_MUL: if (unit_stat.done) state_d = S_POS;
      S_PD_CHK:  state_d = in_dead_zone ? S_POS : S_PD_KP;
      S_PD_KP:   if (unit_stat.done) state_d = S_PD_KD;
      S_PD_KD:   if (unit_stat.done) state_d = S_PD_OUT;
      S_PD_OUT:  state_d = S_PD_LIM;
      S_PD_LIM:  state_d = S_POS;
      S_POS:     state_d = (pos_nonpos || pos_full) ? S_EMIT : S_DIV;
      S_DIV:     if (unit_stat.done) state_d = S_EMIT;
      S_EMIT:    if (emit) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o        = (state_q != S_IDLE);
    unit_cmd.start    = 1'b0;
    unit_cmd.op       = OP_MUL;
    unit_cmd.keep_acc = 1'b0;
    unit_opa          = pos_ext;
    unit_opb          = mp_q;
    unique case (state_q)
      S_EXEC: begin
        if (mode_q == MODE_TARGET) begin
          unit_cmd.start = 1'b1;
          unit_opa       = mp_ext;
          unit_opb       = {{(MP_W-FRAC_W){1'b0}}, frac_clamp};
        end
      end
      S_PD_CHK: begin
        unit_cmd.start = !in_dead_zone;
        unit_opa       = err_sat;
        unit_opb       = {{(MP_W-GAIN_W){1'b0}}, kp_q};
      end
      S_PD_KP: begin
        unit_cmd.start    = unit_stat.done;
        unit_cmd.keep_acc = 1'b1;
        unit_opa          = der_sat;
        unit_opb          = {{(MP_W-GAIN_W){1'b0}}, kd_q};
      end
      S_POS: begin
        unit_cmd.start = !(pos_nonpos || pos_full);
        unit_cmd.op    = OP_DIV;
      end
      default: ;
    endcase
  end

  // controller datapath
  always_comb begin
    position_d = position_q;
    target_d   = target_q;
    last_err_d = last_err_q;
    err_d      = err_q;
    der_d      = der_q;
    homed_d    = homed_q;
    moving_d   = moving_q;
    drive_d    = drive_q;
    idle_d     = idle_q;
    trunc_d    = trunc_q;
    pf_d       = pf_q;
    unique case (state_q)
      S_EXEC: begin
        err_d = {target_q[POS_BITS-1], target_q} - {position_q[POS_BITS-1], position_q};
        unique case (mode_q)
          MODE_EDGE: begin
            // all ones steps down, one steps up
            position_d = position_q + {{(POS_BITS-1){~b_q}}, 1'b1};
            if (!homed_q) idle_d = '0;
          end
          MODE_TICK: begin
            if (!homed_q) begin
              if (idle_inc >= stall_q) begin
                drive_d    = '0;
                position_d = '0;
                target_d   = '0;
                last_err_d = '0;
                homed_d    = 1'b1;
                idle_d     = '0;
              end else begin
                idle_d = idle_inc;
              end
            end
          end
          MODE_REHOME: begin
            homed_d = 1'b0;
            idle_d  = '0;
            drive_d = -$signed({{(DRV_W-DUTY_W){1'b0}}, hduty_q});
          end
          default: ;
        endcase
      end
      S_TGT_MUL: begin
        if (unit_stat.done) target_d = unit_acc[POS_BITS+15:16];
      end
      S_PD_CHK: begin
        if (in_dead_zone) begin
          if (moving_q) begin
            drive_d  = '0;
            moving_d = 1'b0;
          end
          last_err_d = '0;
        end else begin
          der_d      = {err_q[ERR_W-1], err_q} - {last_err_q[ERR_W-1], last_err_q};
          last_err_d = err_q;
        end
      end
      S_PD_OUT: trunc_d = acc_bias[ACC_W-1:GAIN_FRAC];
      S_PD_LIM: begin
        moving_d = 1'b1;
        if (clamp > 0 && clamp < md_s) begin
          drive_d = md_s;
        end else if (clamp < 0 && clamp > -md_s) begin
          drive_d = -md_s;
        end else begin
          drive_d = clamp;
        end
      end
      S_POS: begin
        if (pos_nonpos) begin
          pf_d = '0;
        end else if (pos_full) begin
          pf_d = FRAC_ONE;
        end
      end
      S_DIV: begin
        if (unit_stat.done) pf_d = {{(FRAC_W-DIV_STEPS){1'b0}}, unit_quo};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      position_q <= '0;
      target_q   <= '0;
      last_err_q <= '0;
      homed_q    <= 1'b0;
      moving_q   <= 1'b0;
      drive_q    <= DRV_RST;
      idle_q     <= '0;
    end else begin
      state_q    <= state_d;
      position_q <= position_d;
      target_q   <= target_d;
      last_err_q <= last_err_d;
      homed_q    <= homed_d;
      moving_q   <= moving_d;
      drive_q    <= drive_d;
      idle_q     <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= mode_i;
      b_q    <= b_level_i;
      frac_q <= target_fraction_i;
    end
    err_q   <= err_d;
    der_q   <= der_d;
    trunc_q <= trunc_d;
    pf_q    <= pf_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (drive_q > 0) begin
        dir_q <= DIR_FWD;
      end else if (drive_q < 0) begin
        dir_q <= DIR_REV;
      end else begin
        dir_q <= DIR_BRAKE;
      end
      duty_q <= drv_mag[DUTY_W-1:0];
      if (!homed_q) begin
        mstate_q <= MS_HOMING;
      end else if (moving_q) begin
        mstate_q <= MS_MOVING;
      end else begin
        mstate_q <= MS_HOLDING;
      end
      raw_q <= pos_ext[RAW_W-1:0];
      pfo_q <= pf_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign bridge_dir_o        = dir_q;
  assign duty_o              = duty_q;
  assign motor_state_o       = mstate_q;
  assign raw_position_o      = raw_q;
  assign position_fraction_o = pfo_q;

  `HPD_ASSERT(a_unit_busy_in_wait, unit_stat.busy |-> (state_q == S_TGT_MUL ||
      state_q == S_PD_KP || state_q == S_PD_KD || state_q == S_DIV))
  `HPD_ASSERT(a_homing_clears, $rose(homed_q) |->
      (drive_q == '0 && position_q == '0 && target_q == '0 && last_err_q == '0))
  `HPD_ASSERT(a_fraction_range, out_valid_o |-> (position_fraction_o <= FRAC_ONE))
  `HPD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (state_q == S_IDLE && !out_valid_o))

endmodule
